@@ src/tmaf_pkg.sv @@
// ----------------------------------------------------------------------------
// tmaf_pkg
// shared widths, reset values and control types of the trimmed moving
// average filter
// ----------------------------------------------------------------------------
package tmaf_pkg;

   localparam int MAX_WINDOW = 16;
   localparam int SAMPLE_W   = 16;
   localparam int LEN_W      = 5;
   localparam int IDX_W      = $clog2(MAX_WINDOW);
   localparam int SUM_W      = SAMPLE_W + IDX_W;
   localparam int DIV_W      = IDX_W;

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(8);
   localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(3);
   localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_WINDOW);

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

@@ src/tmaf_div.sv @@
// ----------------------------------------------------------------------------
// tmaf_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tmaf_div (
   input  logic                           clock,
   input  logic                           reset,
   input  tmaf_pkg::div_req_type          req,
   output tmaf_pkg::div_stat_type         stat,
   output logic [tmaf_pkg::SAMPLE_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(tmaf_pkg::SUM_W);
   localparam int REM_W = tmaf_pkg::DIV_W + 1;

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [tmaf_pkg::SUM_W-1:0] dvd_ff, dvd_in;
   logic [tmaf_pkg::DIV_W-1:0] rem_ff, rem_in;
   logic [tmaf_pkg::DIV_W-1:0] dsr_ff, dsr_in;
   logic [REM_W-1:0]           trial;
   logic [REM_W-1:0]           diff;
   logic                       qbit;

   always_comb begin
      trial = {rem_ff, dvd_ff[tmaf_pkg::SUM_W-1]};
      qbit  = (trial >= {1'b0, dsr_ff});
      diff  = trial - {1'b0, dsr_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;

      if (busy_ff) begin
         dvd_in = {dvd_ff[tmaf_pkg::SUM_W-2:0], qbit};
         rem_in = qbit ? diff[tmaf_pkg::DIV_W-1:0] : trial[tmaf_pkg::DIV_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(tmaf_pkg::SUM_W - 1);
         dvd_in  = req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = dvd_ff[tmaf_pkg::SAMPLE_W-1:0];

endmodule

@@ src/trimmed_moving_average_filter_core.sv @@
// ----------------------------------------------------------------------------
// trimmed_moving_average_filter_core
// sliding window filter: drops one maximum and one minimum and returns the
// rounded mean of the remaining samples
// ----------------------------------------------------------------------------
// One sample is taken at a time. The history sits in a 16 x 16 bit memory
// with a registered read; each item scans the window newest-last through the
// single read port while shifting it one place through the write port, then
// a one-bit-per-cycle divider forms the mean. With n the clamped window
// length, an item runs through n - 1 reads, one drain, one write of the new
// sample, the division and one output step before the next sample is taken.
// The result waits in an output register, and the next sample is accepted
// once the new result has moved into that register; a result still held
// there delays that move. Entries that were never written read as zero, so
// no clearing pass follows reset.
// window_length is clamped to 3..16.
module trimmed_moving_average_filter_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tmaf_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tmaf_pkg::SAMPLE_W-1:0]  rsp_filtered,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tmaf_pkg::LEN_W-1:0]     csr_window_length
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_READ   = 3'd1;
   localparam logic [2:0] S_DRAIN  = 3'd2;
   localparam logic [2:0] S_WRITE0 = 3'd3;
   localparam logic [2:0] S_DIV    = 3'd4;
   localparam logic [2:0] S_OUT    = 3'd5;

   localparam int SW = tmaf_pkg::SAMPLE_W;
   localparam int IW = tmaf_pkg::IDX_W;
   localparam int UW = tmaf_pkg::SUM_W;

   logic [SW-1:0]                  mem [tmaf_pkg::MAX_WINDOW];
   logic [SW-1:0]                  memq_ff;

   logic [2:0]                     state_ff, state_in;
   logic [tmaf_pkg::LEN_W-1:0]     wl_ff, wl_in;
   logic [SW-1:0]                  fresh_ff, fresh_in;
   logic [IW-1:0]                  hist_ff, hist_in;
   logic [IW-1:0]                  ptr_ff, ptr_in;
   logic                           dv_ff, dv_in;
   logic [IW-1:0]                  didx_ff, didx_in;
   logic                           rvld_ff, rvld_in;
   logic [SW-1:0]                  hi_ff, hi_in;
   logic [SW-1:0]                  lo_ff, lo_in;
   logic [UW-1:0]                  total_ff, total_in;
   logic [tmaf_pkg::MAX_WINDOW-1:0] valid_ff, valid_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]                  rsp_data_ff, rsp_data_in;

   logic [tmaf_pkg::LEN_W-1:0]     n_eff;
   logic [SW-1:0]                  v;
   logic                           we;
   logic [IW-1:0]                  wa;
   logic [SW-1:0]                  wd;
   logic                           rd_en;
   logic [IW-1:0]                  divisor;
   tmaf_pkg::div_req_type          div_req;
   tmaf_pkg::div_stat_type         div_stat;
   logic [SW-1:0]                  quotient;

   always_comb begin
      n_eff = wl_ff;
      if (wl_ff < tmaf_pkg::LEN_MIN) begin
         n_eff = tmaf_pkg::LEN_MIN;
      end else if (wl_ff > tmaf_pkg::LEN_MAX) begin
         n_eff = tmaf_pkg::LEN_MAX;
      end
   end

   assign v       = rvld_ff ? memq_ff : '0;
   assign divisor = hist_ff - IW'(1);
   assign rd_en   = (state_ff == S_READ);

   always_comb begin
      we = 1'b0;
      wa = '0;
      wd = fresh_ff;
      if (dv_ff && (didx_ff != divisor)) begin
         we = 1'b1;
         wa = didx_ff + IW'(1);
         wd = v;
      end else if (state_ff == S_WRITE0) begin
         we = 1'b1;
      end
   end

   always_comb begin
      div_req.start    = (state_ff == S_WRITE0);
      div_req.dividend = total_ff - UW'(hi_ff) - UW'(lo_ff) + UW'(divisor >> 1);
      div_req.divisor  = divisor;
   end

   always_comb begin
      state_in     = state_ff;
      wl_in        = wl_ff;
      fresh_in     = fresh_ff;
      hist_in      = hist_ff;
      ptr_in       = ptr_ff;
      dv_in        = 1'b0;
      didx_in      = didx_ff;
      rvld_in      = rvld_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      total_in     = total_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         wl_in = csr_window_length;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (we) begin
         valid_in[wa] = 1'b1;
      end

      // fold in the entry read last cycle
      if (dv_ff) begin
         hi_in    = (v > hi_ff) ? v : hi_ff;
         lo_in    = (v < lo_ff) ? v : lo_ff;
         total_in = total_ff + UW'(v);
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               fresh_in = req_sample;
               hist_in  = IW'(n_eff - tmaf_pkg::LEN_W'(1));
               ptr_in   = IW'(n_eff - tmaf_pkg::LEN_W'(2));
               hi_in    = req_sample;
               lo_in    = req_sample;
               total_in = UW'(req_sample);
               state_in = S_READ;
            end
         end
         S_READ: begin
            dv_in   = 1'b1;
            didx_in = ptr_ff;
            rvld_in = valid_ff[ptr_ff];
            if (ptr_ff == '0) begin
               state_in = S_DRAIN;
            end else begin
               ptr_in = ptr_ff - IW'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_WRITE0;
         end
         S_WRITE0: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_stat.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = quotient;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wl_ff        <= tmaf_pkg::LEN_RESET;
         dv_ff        <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wl_ff        <= wl_in;
         dv_ff        <= dv_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fresh_ff    <= fresh_in;
      hist_ff     <= hist_in;
      ptr_ff      <= ptr_in;
      didx_ff     <= didx_in;
      rvld_ff     <= rvld_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      total_ff    <= total_in;
      rsp_data_ff <= rsp_data_in;
   end

   // window memory
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (rd_en) begin
         memq_ff <= mem[ptr_ff];
      end
   end

   tmaf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .stat     (div_stat),
      .quotient (quotient)
   );

   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_data_ff;
   assign csr_ready    = 1'b1;

`ifndef NO_ASSERTIONS
   a_shift_in_window: assert property (@(posedge clock) disable iff (reset)
      (we && (state_ff != S_WRITE0)) |-> (wa < hist_ff))
      else $error("window shift writes beyond the active history");

   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT))
      else $error("result item raised outside the output step");

   a_no_read_while_fold_write0: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE0) |-> !dv_ff)
      else $error("entry zero write collides with a shift write");
`endif

endmodule

@@ tb/trimmed_moving_average_filter_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trimmed_moving_average_filter_core_tb
// self-checking testbench of the trimmed moving average filter core
// ----------------------------------------------------------------------------
// Samples are driven from a queue through the req channel. Every accepted
// item is run through a local window predictor, and each filtered result is
// compared in order with the predicted value. Window lengths below, inside
// and above the legal range are written between phases. Sender gaps,
// receiver stalls and one long receiver hold-off are mixed in.
// ----------------------------------------------------------------------------
module trimmed_moving_average_filter_core_tb;

   localparam int SW            = tmaf_pkg::SAMPLE_W;
   localparam int LW            = tmaf_pkg::LEN_W;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 60;

   logic                clock             = 1'b0;
   logic                reset             = 1'b1;
   logic                req_valid         = 1'b0;
   logic                req_stall;
   logic [SW-1:0]       req_sample        = '0;
   logic                rsp_valid;
   logic                rsp_stall         = 1'b0;
   logic [SW-1:0]       rsp_filtered;
   logic                csr_valid         = 1'b0;
   logic                csr_ready;
   logic [LW-1:0]       csr_window_length = tmaf_pkg::LEN_RESET;

   // predictor state
   logic [SW-1:0]       history [tmaf_pkg::MAX_WINDOW] = '{default: '0};
   logic [LW-1:0]       window_length_reg    = tmaf_pkg::LEN_RESET;

   logic [SW-1:0] sample_backlog[$];
   logic [SW-1:0] expected_filtered[$];
   logic [SW-1:0] recent_sample = '0;

   logic req_taken    = 1'b0;
   logic hold_request = 1'b0;
   logic hold_served  = 1'b0;
   int   hold_left    = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   error_count   = 0;
   int   samples_in    = 0;
   int   results_out   = 0;
   int   lengths_written = 0;

   trimmed_moving_average_filter_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_filtered      (rsp_filtered),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_window_length (csr_window_length)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic filter_sample(input logic [SW-1:0] fresh,
                                output logic [SW-1:0] filtered);
      int span;
      int hist;
      int hi;
      int lo;
      int total;
      int divisor;
      span = int'(window_length_reg);
      if (span < int'(tmaf_pkg::LEN_MIN)) span = int'(tmaf_pkg::LEN_MIN);
      if (span > int'(tmaf_pkg::LEN_MAX)) span = int'(tmaf_pkg::LEN_MAX);
      hist    = span - 1;
      divisor = span - 2;
      hi      = int'(fresh);
      lo      = int'(fresh);
      total   = int'(fresh);
      for (int k = 0; k < hist; k++) begin
         if (int'(history[k]) > hi) hi = int'(history[k]);
         if (int'(history[k]) < lo) lo = int'(history[k]);
         total += int'(history[k]);
      end
      for (int k = hist - 1; k > 0; k--) begin
         history[k] = history[k-1];
      end
      history[0] = fresh;
      total = (total - hi - lo + divisor / 2) / divisor;
      filtered = SW'(total);
   endtask

   function automatic logic [SW-1:0] next_sample();
      logic [SW-1:0] v;
      case ($urandom_range(9))
         0, 1, 2, 3: v = SW'($urandom);
         4, 5:       v = recent_sample + SW'($urandom_range(64)) - SW'(32);
         6:          v = $urandom_range(1) ? '1 : '0;
         7:          v = recent_sample;
         default:    v = {2'b11, 14'($urandom)};
      endcase
      recent_sample = v;
      return v;
   endfunction

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid  <= 1'b1;
            req_sample <= sample_backlog.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall, with one long hold-off on request
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_served) begin
         rsp_stall   <= 1'b1;
         hold_left   <= HOLD_CYCLES;
         hold_served <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // monitor and checker
   always @(posedge clock) begin : check
      logic [SW-1:0] predicted;
      logic [SW-1:0] wanted;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            results_out++;
            if (expected_filtered.size() == 0) begin
               $error("filtered: unexpected item, actual %0d", rsp_filtered);
               error_count++;
            end else begin
               wanted = expected_filtered.pop_front();
               if (rsp_filtered !== wanted) begin
                  $error("filtered: expected %0d, actual %0d", wanted, rsp_filtered);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            filter_sample(req_sample, predicted);
            expected_filtered.push_back(predicted);
            samples_in++;
         end
      end
   end

   task automatic drain();
      while (sample_backlog.size() != 0 || req_valid || expected_filtered.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_window_length(input logic [LW-1:0] value);
      @(negedge clock);
      csr_valid         <= 1'b1;
      csr_window_length <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      window_length_reg = value;
      lengths_written++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [LW-1:0] length, input int count,
                            input int s_pct, input int r_pct);
      load_window_length(length);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (count) sample_backlog.push_back(next_sample());
      drain();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // extremes, equal runs and a full window at maximum, reset length
      sample_backlog = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                         16'd1234, 16'd1234, 16'd1234, 16'd1234, 16'd1234,
                         16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'h0000, 16'h0001, 16'hFFFE, 16'h5555, 16'hAAAA};
      drain();

      run_phase(LW'(3), 100, 79, 0);
      run_phase(LW'(16), 100, 0, 79);
      run_phase(LW'(0), 60, 10, 10);
      hold_request = 1'b1;
      run_phase(LW'(31), 80, 0, 0);
      run_phase(LW'(5), 80, 10, 10);
      run_phase(LW'(2), 40, 0, 79);
      run_phase(LW'(17), 60, 79, 0);
      run_phase(LW'(12), 100, 0, 0);
      repeat (4) begin
         run_phase(LW'($urandom_range(31)), 30,
                   $urandom_range(1) ? 79 : 10, $urandom_range(1) ? 79 : 0);
      end

      if (expected_filtered.size() != 0) begin
         $error("filtered: %0d items never arrived", expected_filtered.size());
         error_count++;
      end
      $display("Ran %0d samples, checked %0d filtered items, %0d window length writes",
               samples_in, results_out, lengths_written);
      $display("Lengths below, inside and above range; gaps, stalls and a long hold-off");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ trimmed_moving_average_filter_core.f @@
src/tmaf_pkg.sv
src/tmaf_div.sv
src/trimmed_moving_average_filter_core.sv
tb/trimmed_moving_average_filter_core_tb.sv
